// ===== hdl/tptk_pkg.sv =====
// Shared types and constants for the three-cable positioner kinematics unit
package tptk_pkg;

	typedef enum logic [1:0] {
		CFG_ANCHOR_B_X = 2'd0,
		CFG_ANCHOR_C_X = 2'd1,
		CFG_ANCHOR_C_Y = 2'd2,
		CFG_NEG_TOL    = 2'd3
	} tptk_cfg_idx_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} tptk_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S0,
		ST_S1,
		ST_S2,
		ST_DIV_X,
		ST_CX,
		ST_CY,
		ST_P,
		ST_DIV_Y,
		ST_XX,
		ST_YY,
		ST_SQRT_Z,
		ST_INV_B,
		ST_INV_C,
		ST_INV_A,
		ST_SQRT_L0,
		ST_INV_BX,
		ST_SQRT_L1,
		ST_INV_CX,
		ST_INV_CY,
		ST_SQRT_L2,
		ST_OUT
	} tptk_state_t;

	localparam logic [6:0] MUL_STEPS  = 7'd32;
	localparam logic [6:0] DIV_STEPS  = 7'd64;
	localparam logic [6:0] SQRT_STEPS = 7'd32;

	localparam logic [30:0] RST_ANCHOR_B_X = 31'd131072;
	localparam logic [31:0] RST_ANCHOR_C_X = 32'd65536;
	localparam logic [30:0] RST_ANCHOR_C_Y = 31'd113512;
	localparam logic [15:0] RST_NEG_TOL    = 16'd1;

	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic              req_type;
		logic signed [31:0] in_a;
		logic signed [31:0] in_b;
		logic signed [31:0] in_c;
	} tptk_in_t;

	typedef struct packed {
		logic signed [31:0] out_a;
		logic signed [31:0] out_b;
		logic signed [31:0] out_c;
		logic              status;
	} tptk_out_t;

	typedef struct packed {
		logic        start;
		tptk_op_t    op;
		logic [63:0] opa;
		logic [32:0] opb;
	} tptk_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} tptk_rsp_t;

endpackage

// ===== hdl/tptk_arith.sv =====
// Shared bit-serial multiply, divide and square root unit
module tptk_arith import tptk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tptk_cmd_t cmd,
	output tptk_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	tptk_op_t    op_q;
	logic [6:0]  cnt_q;
	logic [63:0] w_q;
	logic [32:0] b_q;
	logic [33:0] r_q;
	logic [31:0] root_q;

	logic [32:0] mul_sum;
	logic [33:0] div_t;
	logic [33:0] div_dif;
	logic        div_ge;
	logic [35:0] sq_t;
	logic [35:0] sq_trial;
	logic [35:0] sq_dif;
	logic        sq_ge;

	always_comb begin
		mul_sum  = {1'b0, w_q[63:32]} + (w_q[0] ? b_q : 33'd0);
		div_t    = {r_q[32:0], w_q[63]};
		div_ge   = div_t >= {1'b0, b_q};
		div_dif  = div_t - {1'b0, b_q};
		sq_t     = {r_q, w_q[63:62]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = sq_t >= sq_trial;
		sq_dif   = sq_t - sq_trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				case (cmd.op)
					OP_DIV:  cnt_q <= DIV_STEPS;
					OP_SQRT: cnt_q <= SQRT_STEPS;
					default: cnt_q <= MUL_STEPS;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			b_q    <= cmd.opb;
			r_q    <= '0;
			root_q <= '0;
			w_q    <= (cmd.op == OP_MUL) ? {32'd0, cmd.opa[31:0]} : cmd.opa;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: w_q <= {mul_sum, w_q[31:1]};
				OP_DIV: begin
					r_q <= div_ge ? div_dif : div_t;
					w_q <= {w_q[62:0], div_ge};
				end
				OP_SQRT: begin
					r_q    <= sq_ge ? sq_dif[33:0] : sq_t[33:0];
					root_q <= {root_q[30:0], sq_ge};
					w_q    <= {w_q[61:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == OP_SQRT) ? {32'd0, root_q} : w_q;

endmodule

// ===== hdl/tripoint_trilateration_kinematics.sv =====
// Top level: three-cable positioner forward and inverse kinematics
//
//  channel  | signals                                | direction
//  ---------+----------------------------------------+----------
//  request  | in_valid, in_stall, in_data            | in
//  result   | out_valid, out_stall, out_data         | out
//  config   | cfg_wr_en, cfg_index, cfg_data         | in
//
// One request at a time through a radix-2 serial unit shared by every step:
// a forward request uses eight products, two 64-step divides and one root,
// an inverse six squares and three roots.
// Reset restores the anchor registers and takes z above the plane.
// A new request is taken while the last result still waits on out_stall.
module tripoint_trilateration_kinematics import tptk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  tptk_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output tptk_out_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? (33'd0 - v) : v;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [66:0] v);
		if (v > 67'sd2147483647)
			return SAT_POS;
		else if (v < -67'sd2147483648)
			return SAT_NEG;
		else
			return v[31:0];
	endfunction

	tptk_state_t state_q, state_d;
	logic        issued_q;
	logic        start;

	logic [30:0]        bx_q;
	logic signed [31:0] cx_q;
	logic [30:0]        cy_q;
	logic [15:0]        tol_q;
	logic               zneg_q;

	logic               req_q;
	logic signed [31:0] a_q, b_q, c_q;
	logic [63:0]        s0_q, s1_q, s2_q, bc_q, sqc_q;
	logic signed [66:0] acc_q;
	logic [31:0]        ra_q, rb_q, rc_q;
	logic               st_q;
	tptk_out_t          out_q;
	logic               out_valid_q;

	tptk_cmd_t cmd;
	tptk_rsp_t rsp;

	logic [30:0]        bx_e, cy_e;
	logic [32:0]        m_a, m_b, m_c, m_cx, m_x, m_y, m_abx, m_acx, m_bcy;
	logic [32:0]        mul_a, mul_b;
	logic [63:0]        prod, capv;
	logic signed [63:0] diff_s;
	logic [63:0]        diff_mag;
	logic signed [66:0] qs67, x_t, x_r, x_h;
	logic [31:0]        x_new;
	logic [66:0]        acc_mag;
	logic [31:0]        ydiv;
	logic [62:0]        ylim;
	logic               ysat;
	logic signed [66:0] tol_neg;
	logic               derr;
	logic [63:0]        zsrc;
	logic [31:0]        zmag, zval;
	logic               sq_big;
	logic               p_neg;

	tptk_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	always_comb begin
		bx_e     = (bx_q == 31'd0) ? 31'd1 : bx_q;
		cy_e     = (cy_q == 31'd0) ? 31'd1 : cy_q;
		m_a      = mag33({a_q[31], a_q});
		m_b      = mag33({b_q[31], b_q});
		m_c      = mag33({c_q[31], c_q});
		m_cx     = mag33({cx_q[31], cx_q});
		m_x      = mag33({ra_q[31], ra_q});
		m_y      = mag33({rb_q[31], rb_q});
		m_abx    = mag33({a_q[31], a_q} - {2'b00, bx_e});
		m_acx    = mag33({a_q[31], a_q} - {cx_q[31], cx_q});
		m_bcy    = mag33({b_q[31], b_q} - {2'b00, cy_e});
		prod     = rsp.result;

		diff_s   = $signed(s1_q) - $signed(s0_q);
		diff_mag = diff_s[63] ? (64'd0 - diff_s) : diff_s;
		qs67     = diff_s[63] ? (67'sd0 - $signed({3'd0, prod})) : $signed({3'd0, prod});
		x_t      = $signed({36'd0, bx_e}) - qs67;
		x_r      = x_t + $signed({66'd0, x_t[66]});
		x_h      = x_r >>> 1;
		x_new    = sat32(x_h);

		acc_mag  = acc_q[66] ? (67'd0 - acc_q) : acc_q;
		ydiv     = {cy_e, 1'b0};
		ylim     = {ydiv, 31'd0};
		ysat     = acc_mag >= {4'd0, ylim};
		tol_neg  = 67'sd0 - $signed({35'd0, tol_q, 16'd0});
		derr     = acc_q < tol_neg;
		zsrc     = acc_q[66] ? 64'd0 : acc_q[63:0];
		zmag     = prod[31] ? SAT_POS : prod[31:0];
		zval     = zneg_q ? (32'd0 - zmag) : zmag;
		sq_big   = acc_q[66:62] != 5'd0;
		p_neg    = ra_q[31] ^ cx_q[31];
	end

	always_comb begin
		case (state_q)
			ST_S0, ST_INV_A: mul_a = m_a;
			ST_S1, ST_INV_B: mul_a = m_b;
			ST_S2, ST_INV_C: mul_a = m_c;
			ST_CX:           mul_a = m_cx;
			ST_CY:           mul_a = {2'b00, cy_e};
			ST_P, ST_XX:     mul_a = m_x;
			ST_YY:           mul_a = m_y;
			ST_INV_BX:       mul_a = m_abx;
			ST_INV_CX:       mul_a = m_acx;
			ST_INV_CY:       mul_a = m_bcy;
			default:         mul_a = m_a;
		endcase
		mul_b = (state_q == ST_P) ? m_cx : mul_a;
		capv  = (mul_a[32:31] != 2'b00) ? 64'h4000_0000_0000_0000 : prod;

		cmd.start = start;
		case (state_q) inside
			ST_DIV_X: begin
				cmd.op  = OP_DIV;
				cmd.opa = diff_mag;
				cmd.opb = {2'b00, bx_e};
			end
			ST_DIV_Y: begin
				cmd.op  = OP_DIV;
				cmd.opa = acc_mag[63:0];
				cmd.opb = {1'b0, ydiv};
			end
			ST_SQRT_Z: begin
				cmd.op  = OP_SQRT;
				cmd.opa = zsrc;
				cmd.opb = '0;
			end
			ST_SQRT_L0, ST_SQRT_L1, ST_SQRT_L2: begin
				cmd.op  = OP_SQRT;
				cmd.opa = acc_q[63:0];
				cmd.opb = '0;
			end
			default: begin
				cmd.op  = OP_MUL;
				cmd.opa = {32'd0, mul_a[31:0]};
				cmd.opb = {1'b0, mul_b[31:0]};
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = in_data.req_type ? ST_INV_B : ST_S0;
			ST_S0: begin start = !issued_q; if (rsp.done) state_d = ST_S1; end
			ST_S1: begin start = !issued_q; if (rsp.done) state_d = ST_S2; end
			ST_S2: begin start = !issued_q; if (rsp.done) state_d = ST_DIV_X; end
			ST_DIV_X: begin start = !issued_q; if (rsp.done) state_d = ST_CX; end
			ST_CX: begin start = !issued_q; if (rsp.done) state_d = ST_CY; end
			ST_CY: begin start = !issued_q; if (rsp.done) state_d = ST_P; end
			ST_P: begin start = !issued_q; if (rsp.done) state_d = ST_DIV_Y; end
			ST_DIV_Y: begin
				if (!issued_q && ysat) state_d = ST_XX;
				else begin
					start = !issued_q;
					if (rsp.done) state_d = ST_XX;
				end
			end
			ST_XX: begin start = !issued_q; if (rsp.done) state_d = ST_YY; end
			ST_YY: begin start = !issued_q; if (rsp.done) state_d = ST_SQRT_Z; end
			ST_SQRT_Z: begin
				if (!issued_q && derr) state_d = ST_OUT;
				else begin
					start = !issued_q;
					if (rsp.done) state_d = ST_OUT;
				end
			end
			ST_INV_B: begin start = !issued_q; if (rsp.done) state_d = ST_INV_C; end
			ST_INV_C: begin start = !issued_q; if (rsp.done) state_d = ST_INV_A; end
			ST_INV_A: begin start = !issued_q; if (rsp.done) state_d = ST_SQRT_L0; end
			ST_SQRT_L0: begin
				if (!issued_q && sq_big) state_d = ST_INV_BX;
				else begin
					start = !issued_q;
					if (rsp.done) state_d = ST_INV_BX;
				end
			end
			ST_INV_BX: begin start = !issued_q; if (rsp.done) state_d = ST_SQRT_L1; end
			ST_SQRT_L1: begin
				if (!issued_q && sq_big) state_d = ST_INV_CX;
				else begin
					start = !issued_q;
					if (rsp.done) state_d = ST_INV_CX;
				end
			end
			ST_INV_CX: begin start = !issued_q; if (rsp.done) state_d = ST_INV_CY; end
			ST_INV_CY: begin start = !issued_q; if (rsp.done) state_d = ST_SQRT_L2; end
			ST_SQRT_L2: begin
				if (!issued_q && sq_big) state_d = ST_OUT;
				else begin
					start = !issued_q;
					if (rsp.done) state_d = ST_OUT;
				end
			end
			ST_OUT: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			zneg_q      <= 1'b0;
			bx_q        <= RST_ANCHOR_B_X;
			cx_q        <= RST_ANCHOR_C_X;
			cy_q        <= RST_ANCHOR_C_Y;
			tol_q       <= RST_NEG_TOL;
		end else begin
			state_q <= state_d;
			if (start)
				issued_q <= 1'b1;
			else if (rsp.done)
				issued_q <= 1'b0;
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				if (req_q) zneg_q <= c_q[31];
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ANCHOR_B_X: bx_q  <= cfg_data[30:0];
					CFG_ANCHOR_C_X: cx_q  <= cfg_data;
					CFG_ANCHOR_C_Y: cy_q  <= cfg_data[30:0];
					CFG_NEG_TOL:    tol_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				req_q <= in_data.req_type;
				a_q   <= in_data.in_a;
				b_q   <= in_data.in_b;
				c_q   <= in_data.in_c;
				st_q  <= 1'b0;
			end
			ST_S0: if (rsp.done) s0_q <= prod;
			ST_S1: if (rsp.done) s1_q <= prod;
			ST_S2: if (rsp.done) s2_q <= prod;
			ST_DIV_X: if (rsp.done) ra_q <= x_new;
			ST_CX: if (rsp.done)
				acc_q <= $signed({3'd0, s0_q}) + $signed({3'd0, prod}) - $signed({3'd0, s2_q});
			ST_CY: if (rsp.done) acc_q <= acc_q + $signed({3'd0, prod});
			ST_P: if (rsp.done) begin
				if (p_neg) acc_q <= acc_q + $signed({2'd0, prod, 1'b0});
				else       acc_q <= acc_q - $signed({2'd0, prod, 1'b0});
			end
			ST_DIV_Y: begin
				if (!issued_q && ysat)
					rb_q <= acc_q[66] ? SAT_NEG : SAT_POS;
				else if (rsp.done)
					rb_q <= acc_q[66] ? (32'd0 - prod[31:0]) : prod[31:0];
			end
			ST_XX: if (rsp.done) acc_q <= $signed({3'd0, s0_q}) - $signed({3'd0, prod});
			ST_YY: if (rsp.done) acc_q <= acc_q - $signed({3'd0, prod});
			ST_SQRT_Z: begin
				if (!issued_q && derr) begin
					st_q <= 1'b1;
					rc_q <= 32'd0;
				end else if (rsp.done) begin
					rc_q <= zval;
				end
			end
			ST_INV_B: if (rsp.done) bc_q <= capv;
			ST_INV_C: if (rsp.done) begin
				sqc_q <= capv;
				bc_q  <= bc_q + capv;
			end
			ST_INV_A: if (rsp.done) acc_q <= $signed({3'd0, bc_q}) + $signed({3'd0, capv});
			ST_SQRT_L0: begin
				if (!issued_q && sq_big) ra_q <= SAT_POS;
				else if (rsp.done)       ra_q <= prod[31:0];
			end
			ST_INV_BX: if (rsp.done) acc_q <= $signed({3'd0, bc_q}) + $signed({3'd0, capv});
			ST_SQRT_L1: begin
				if (!issued_q && sq_big) rb_q <= SAT_POS;
				else if (rsp.done)       rb_q <= prod[31:0];
			end
			ST_INV_CX: if (rsp.done) acc_q <= $signed({3'd0, sqc_q}) + $signed({3'd0, capv});
			ST_INV_CY: if (rsp.done) acc_q <= acc_q + $signed({3'd0, capv});
			ST_SQRT_L2: begin
				if (!issued_q && sq_big) rc_q <= SAT_POS;
				else if (rsp.done)       rc_q <= prod[31:0];
			end
			ST_OUT: if (!out_valid_q || !out_stall) begin
				out_q.out_a  <= ra_q;
				out_q.out_b  <= rb_q;
				out_q.out_c  <= rc_q;
				out_q.status <= st_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== dv/tb_tripoint_trilateration_kinematics.sv =====
// Testbench for the three-cable positioner kinematics unit, self-checking against a predictor
`timescale 1ns / 1ps

module tb_tripoint_trilateration_kinematics;
	import tptk_pkg::*;

	localparam int DRAIN     = 600;
	localparam int HOLD_LEN  = 3000;
	localparam int WD_LIMIT  = 20000;
	localparam int PER_PHASE = 217;
	localparam longint Q     = 65536;
	localparam longint SMAX  = 64'sd2147483647;
	localparam longint SMIN  = -64'sd2147483648;

	typedef struct {
		logic      req;
		logic [31:0] a, b, c;
		logic      typed;
		tptk_out_t res;
	} dir_row_t;

	typedef struct {
		logic      typed;
		tptk_out_t res;
	} typed_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	tptk_in_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	tptk_out_t out_data;
	logic      cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = CFG_ANCHOR_B_X;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic [30:0]        p_bx = RST_ANCHOR_B_X;
	logic signed [31:0] p_cx = RST_ANCHOR_C_X;
	logic [30:0]        p_cy = RST_ANCHOR_C_Y;
	logic [15:0]        p_tol = RST_NEG_TOL;
	logic               p_below = 1'b0;

	tptk_out_t pending_q[$];
	typed_t    typed_q[$];
	dir_row_t  dir_tab[$];
	int        n_err = 0;
	int        idle_cnt = 0;
	int        send_pct = 0, recv_pct = 0;
	int        hold_req = 0, hold_seen = 0, hold_left = 0;

	tripoint_trilateration_kinematics u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint sat32(input longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] rem, r, b;
		rem = v;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] cap_sq(input longint v);
		logic [63:0] m;
		m = (v < 0) ? -v : v;
		return (m >= 64'h8000_0000) ? 64'h4000_0000_0000_0000 : m * m;
	endfunction

	function automatic longint span3(input longint a, input longint b, input longint c);
		logic [63:0] s;
		s = cap_sq(a) + cap_sq(b) + cap_sq(c);
		if (s >= 64'h4000_0000_0000_0000) return SMAX;
		return longint'(isqrt(s));
	endfunction

	function automatic tptk_out_t calc_kinematics(input tptk_in_t d);
		longint a, b, c, bx, cy, cx, s0, s1, s2, q, x, y, p, dd, ra, rb, rc;
		logic signed [127:0] num, t;
		logic [127:0] m, dv;
		logic [63:0] z;
		logic st;
		tptk_out_t r;
		a = longint'(d.in_a);
		b = longint'(d.in_b);
		c = longint'(d.in_c);
		bx = (p_bx == 0) ? 1 : longint'({33'd0, p_bx});
		cy = (p_cy == 0) ? 1 : longint'({33'd0, p_cy});
		cx = longint'(p_cx);
		st = 1'b0;
		if (d.req_type == 1'b0) begin
			s0 = a * a;
			s1 = b * b;
			s2 = c * c;
			q = (s1 - s0) / bx;
			x = sat32((bx - q) / 2);
			num = s0;
			num = num + cx * cx;
			num = num + cy * cy;
			num = num - s2;
			p = x * cx;
			t = p;
			num = num - t * 2;
			m = (num < 0) ? -num : num;
			dv = 2 * cy;
			if (m >= (dv << 31)) y = (num < 0) ? SMIN : SMAX;
			else begin
				y = longint'(m / dv);
				if (num < 0) y = -y;
			end
			dd = s0 - x * x - y * y;
			ra = x;
			rb = y;
			if (dd < -(longint'(p_tol) * Q)) begin
				st = 1'b1;
				rc = 0;
			end else begin
				if (dd < 0) dd = 0;
				z = isqrt(dd);
				if (z > SMAX) z = SMAX;
				rc = p_below ? -longint'(z) : longint'(z);
			end
		end else begin
			ra = span3(a, b, c);
			rb = span3(a - bx, b, c);
			rc = span3(a - cx, b - cy, c);
			p_below = (c < 0);
		end
		r.out_a = ra[31:0];
		r.out_b = rb[31:0];
		r.out_c = rc[31:0];
		r.status = st;
		return r;
	endfunction

	// transfer monitors, scoreboard and watchdog
	always @(posedge clk) begin
		tptk_out_t want;
		typed_t tp;
		logic moved;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			moved = 1'b1;
			want = calc_kinematics(in_data);
			tp = typed_q.pop_front();
			pending_q.push_back(tp.typed ? tp.res : want);
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (pending_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result %h", out_data);
			end else begin
				want = pending_q.pop_front();
				if (out_data.out_a !== want.out_a || out_data.out_b !== want.out_b ||
				    out_data.out_c !== want.out_c || out_data.status !== want.status) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch exp a=%h b=%h c=%h st=%b got a=%h b=%h c=%h st=%b",
							want.out_a, want.out_b, want.out_c, want.status,
							out_data.out_a, out_data.out_b, out_data.out_c, out_data.status);
				end
			end
		end
		idle_cnt <= moved ? 0 : idle_cnt + 1;
		if (idle_cnt >= WD_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stall plus one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else out_stall <= ($urandom_range(99) < recv_pct);
	end

	task automatic send(input tptk_in_t d, input logic typed, input tptk_out_t res);
		typed_t tp;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		tp.typed = typed;
		tp.res = res;
		typed_q.push_back(tp);
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic cfg_set(input logic [31:0] bx, cx, cy, tol);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ANCHOR_B_X;
		cfg_data <= bx;
		@(posedge clk);
		cfg_index <= CFG_ANCHOR_C_X;
		cfg_data <= cx;
		@(posedge clk);
		cfg_index <= CFG_ANCHOR_C_Y;
		cfg_data <= cy;
		@(posedge clk);
		cfg_index <= CFG_NEG_TOL;
		cfg_data <= tol;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		p_bx = bx[30:0];
		p_cx = cx;
		p_cy = cy[30:0];
		p_tol = tol[15:0];
	endtask

	function automatic longint rnd_coord();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return longint'($urandom_range(0, 32'h40_0000)) - 64'sh20_0000;
			6, 7: return longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000;
			default: return longint'($signed($urandom));
		endcase
	endfunction

	function automatic tptk_in_t gen_item();
		tptk_in_t d;
		longint x, y, z, bx, cy, j0, j1, j2;
		x = rnd_coord();
		y = rnd_coord();
		z = rnd_coord();
		bx = (p_bx == 0) ? 1 : longint'({33'd0, p_bx});
		cy = (p_cy == 0) ? 1 : longint'({33'd0, p_cy});
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6, 7: begin
				d.req_type = 1'b1;
				d.in_a = x[31:0];
				d.in_b = y[31:0];
				d.in_c = z[31:0];
			end
			8, 9, 10, 11, 12, 13, 14, 15, 16: begin
				// lengths from a real point, nudged a few LSBs either way
				j0 = longint'($urandom_range(6)) - 3;
				j1 = longint'($urandom_range(6)) - 3;
				j2 = longint'($urandom_range(6)) - 3;
				d.req_type = 1'b0;
				d.in_a = 32'(span3(x, y, z) + j0);
				d.in_b = 32'(span3(x - bx, y, z) + j1);
				d.in_c = 32'(span3(x - longint'(p_cx), y - cy, z) + j2);
			end
			default: begin
				d.req_type = 1'b0;
				d.in_a = $urandom;
				d.in_b = $urandom;
				d.in_c = $urandom;
			end
		endcase
		return d;
	endfunction

	initial begin
		tptk_in_t d;
		tptk_out_t none;
		logic [31:0] cfg_tab[6][4];
		none = '0;
		cfg_tab = '{
			'{32'd131072, 32'd65536, 32'd113512, 32'd1},
			'{32'd1, 32'h8000_0000, 32'd1, 32'd0},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535},
			'{32'd0, -32'sd65536, 32'd0, 32'd100},
			'{32'd200000, 32'd30000, 32'd150000, 32'd65535},
			'{32'd131072, -32'sd40000, 32'd90000, 32'd4}
		};
		dir_tab.push_back('{1'b1, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd131072, 32'd131072, 1'b0}});
		dir_tab.push_back('{1'b0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd65536, 32'd37837, 32'd0, 1'b1}});
		dir_tab.push_back('{1'b0, 32'd65536, 32'd65536, 32'd113512, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b0, none});
		dir_tab.push_back('{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
			'{SAT_POS, SAT_POS, SAT_POS, 1'b0}});
		dir_tab.push_back('{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
			'{SAT_POS, SAT_POS, SAT_POS, 1'b0}});
		dir_tab.push_back('{1'b0, 32'd98304, 32'd98304, 32'd80000, 1'b0, none});
		dir_tab.push_back('{1'b1, 32'd65536, 32'd32768, 32'd65536, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'd98304, 32'd98304, 32'd80000, 1'b0, none});
		dir_tab.push_back('{1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'd98304, 32'd98304, 32'd80000, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'd1, 32'hFFFF_FFFF, 32'd1, 1'b0, none});
		dir_tab.push_back('{1'b1, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'h4000_0000, 32'd0, 32'd0, 1'b0, none});
		dir_tab.push_back('{1'b0, 32'd65535, 32'd65536, 32'd113512, 1'b0, none});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			d.req_type = dir_tab[i].req;
			d.in_a = dir_tab[i].a;
			d.in_b = dir_tab[i].b;
			d.in_c = dir_tab[i].c;
			send(d, dir_tab[i].typed, dir_tab[i].res);
		end

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			cfg_set(cfg_tab[ph][0], cfg_tab[ph][1], cfg_tab[ph][2], cfg_tab[ph][3]);
			if (ph == 0) hold_req = hold_req + 1;
			send_pct = (ph < 2) ? 31 : (ph < 4) ? 61 : 0;
			recv_pct = (ph < 2) ? 61 : (ph < 4) ? 31 : 0;
			repeat (PER_PHASE) send(gen_item(), 1'b0, none);
		end
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (n_err == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tptk_pkg.sv
hdl/tptk_arith.sv
hdl/tripoint_trilateration_kinematics.sv
dv/tb_tripoint_trilateration_kinematics.sv
